// ===== hdl/connection_lifecycle_controller_assert.svh =====
// Assertion macros for the connection lifecycle controller.
`ifndef CONNECTION_LIFECYCLE_CONTROLLER_ASSERT_SVH
`define CONNECTION_LIFECYCLE_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

`define CLC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define CLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CLC_ASSERT_SAME(label, clk, rst, ante, cons)

`define CLC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/clc_pkg.sv =====
`default_nettype none

package clc_pkg;

   localparam int unsigned CfgWidth   = 16;
   localparam int unsigned GenWidth   = 32;
   localparam logic [CfgWidth-1:0] TimeoutReset = 16'd1000;

   typedef enum logic [1:0] {
      CFG_CONNECT_TIMEOUT    = 2'd0,
      CFG_DISCONNECT_TIMEOUT = 2'd1,
      CFG_CANCEL_TIMEOUT     = 2'd2
   } cfg_index_type;

   typedef enum logic [2:0] {
      REQ_CONNECT         = 3'd0,
      REQ_CANCEL          = 3'd1,
      REQ_TEARDOWN        = 3'd2,
      REQ_DISCONNECT      = 3'd3,
      REQ_CONNECT_DONE    = 3'd4,
      REQ_DISCONNECT_DONE = 3'd5,
      REQ_LINK_EVENT      = 3'd6,
      REQ_TICK            = 3'd7
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DISCONNECTED  = 2'd0,
      ST_CONNECTING    = 2'd1,
      ST_CONNECTED     = 2'd2,
      ST_DISCONNECTING = 2'd3
   } link_state_type;

   typedef enum logic [1:0] {
      STATUS_SUCCESS          = 2'd0,
      STATUS_INVALID_STATE    = 2'd1,
      STATUS_CONNECT_FAILED   = 2'd2,
      STATUS_DISCONNECT_FAILED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FAIL_NONE         = 2'd0,
      FAIL_TRANSPORT    = 2'd1,
      FAIL_CANCELLED    = 2'd2,
      FAIL_UNRESPONSIVE = 2'd3
   } failure_type;

   typedef enum logic [1:0] {
      STAGE_CONNECT    = 2'd0,
      STAGE_CANCEL     = 2'd1,
      STAGE_DISCONNECT = 2'd2
   } stage_type;

   // First member sits in the top bits.
   typedef struct packed {
      logic [GenWidth-1:0] current_generation;
      link_state_type      current_state;
      stage_type           event_stage;
      failure_type         event_failure;
      logic [GenWidth-1:0] event_generation;
      link_state_type      event_state;
      logic                event_valid;
      status_type          status;
   } result_type;

   localparam int unsigned ResultWidth = $bits(result_type);
   localparam int unsigned RspWidth    = ((ResultWidth + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== hdl/connection_lifecycle_controller.sv =====
// Channel   Ports             Contents
// req       req_t*            tuser: req_type; tdata: tag, flags
// rsp       rsp_t*            tdata: status, event, current state and generation
// csr       csr_we/index/wdata  timeout registers, write only
//
// One transaction per cycle while req_tready is high: each request updates the state
// in the cycle it is accepted; its result is registered in the output or skid register.
// An output register plus a one-entry skid buffer: req_tready falls only
// when both hold a result.
// Synchronous active-high reset: disconnected, generation 0, timeouts 1000.
`default_nettype none

`include "connection_lifecycle_controller_assert.svh"

module connection_lifecycle_controller (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [39:0]  req_tdata,  // tag[31:0], ok, tfail, link_down,
                                         // start_ok, cancel_accepted, zero pad
   input  wire logic [2:0]   req_tuser,  // req_type
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [79:0]       rsp_tdata,  // status[1:0], event_valid, event_state[1:0],
                                         // event_generation[31:0], event_failure[1:0],
                                         // event_stage[1:0], current_state[1:0],
                                         // current_generation[31:0], zero pad
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   import clc_pkg::*;

   logic [CfgWidth-1:0] conn_to_ff, disc_to_ff, cancel_to_ff;

   link_state_type      state_ff, state_in;
   logic [GenWidth-1:0] gen_ff, gen_in;
   logic                cancel_ff, cancel_in;
   logic                tdown_ff, tdown_in;
   logic                pend_ff, pend_in;
   logic                armed_ff, armed_in;
   logic [CfgWidth-1:0] left_ff, left_in;
   stage_type           stage_ff, stage_in;

   result_type          out_ff, skid_ff, res;
   logic                out_valid_ff, skid_valid_ff;

   req_kind_type        kind;
   logic [GenWidth-1:0] tag;
   logic                ok, tfail, down, start_ok, cancel_ok;
   logic                acc, out_take, tag_match;
   logic                conn_done_hit, disc_done_hit, link_hit, tick_live, tick_fire;

   assign kind      = req_kind_type'(req_tuser);
   assign tag       = req_tdata[31:0];
   assign ok        = req_tdata[32];
   assign tfail     = req_tdata[33];
   assign down      = req_tdata[34];
   assign start_ok  = req_tdata[35];
   assign cancel_ok = req_tdata[36];

   assign req_tready = !skid_valid_ff;
   assign acc        = req_tvalid && req_tready;
   assign out_take   = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspWidth-ResultWidth){1'b0}}, out_ff};

   assign tag_match     = (tag == gen_ff);
   assign conn_done_hit = tag_match && pend_ff &&
                          (state_ff == ST_CONNECTING || state_ff == ST_DISCONNECTING);
   assign disc_done_hit = tag_match && pend_ff && (state_ff == ST_DISCONNECTING);
   assign link_hit      = tag_match && (state_ff == ST_CONNECTED) && down;
   assign tick_live     = pend_ff && armed_ff;
   assign tick_fire     = tick_live && (left_ff[CfgWidth-1:1] == '0);

   // next state
   always_comb begin
      state_in  = state_ff;
      gen_in    = gen_ff;
      cancel_in = cancel_ff;
      tdown_in  = tdown_ff;
      pend_in   = pend_ff;
      armed_in  = armed_ff;
      left_in   = left_ff;
      stage_in  = stage_ff;
      case (kind)
         REQ_CONNECT: begin
            if (state_ff == ST_DISCONNECTED) begin
               gen_in    = gen_ff + 1'b1;
               cancel_in = 1'b0;
               tdown_in  = 1'b0;
               stage_in  = STAGE_CONNECT;
               left_in   = conn_to_ff;
               state_in  = start_ok ? ST_CONNECTING : ST_DISCONNECTED;
               pend_in   = start_ok;
               armed_in  = start_ok;
            end
         end
         REQ_CANCEL, REQ_TEARDOWN: begin
            if (state_ff == ST_CONNECTING) begin
               tdown_in = 1'b1;
               if (cancel_ok) begin
                  state_in  = ST_DISCONNECTING;
                  cancel_in = 1'b1;
                  stage_in  = STAGE_CANCEL;
                  armed_in  = 1'b1;
                  left_in   = cancel_to_ff;
               end
            end else if (state_ff == ST_CONNECTED && kind == REQ_TEARDOWN) begin
               cancel_in = 1'b0;
               tdown_in  = 1'b0;
               stage_in  = STAGE_DISCONNECT;
               left_in   = disc_to_ff;
               state_in  = start_ok ? ST_DISCONNECTING : ST_CONNECTED;
               pend_in   = start_ok;
               armed_in  = start_ok;
            end
         end
         REQ_DISCONNECT: begin
            if (state_ff == ST_CONNECTED) begin
               stage_in = STAGE_DISCONNECT;
               left_in  = disc_to_ff;
               state_in = start_ok ? ST_DISCONNECTING : ST_CONNECTED;
               pend_in  = start_ok;
               armed_in = start_ok;
            end
         end
         REQ_CONNECT_DONE: begin
            if (conn_done_hit) begin
               pend_in   = 1'b0;
               armed_in  = 1'b0;
               cancel_in = 1'b0;
               tdown_in  = 1'b0;
               if (cancel_ff) begin
                  state_in = (!ok && tfail) ? ST_CONNECTED : ST_DISCONNECTED;
               end else begin
                  state_in = ok ? ST_CONNECTED : ST_DISCONNECTED;
               end
            end
         end
         REQ_DISCONNECT_DONE: begin
            if (disc_done_hit) begin
               pend_in  = 1'b0;
               armed_in = 1'b0;
               state_in = ok ? ST_DISCONNECTED : ST_CONNECTED;
            end
         end
         REQ_LINK_EVENT: begin
            if (link_hit) begin
               state_in = ST_DISCONNECTED;
            end
         end
         default: begin
            if (tick_fire) begin
               pend_in  = 1'b0;
               armed_in = 1'b0;
               left_in  = '0;
            end else if (tick_live) begin
               left_in = left_ff - 1'b1;
            end
         end
      endcase
   end

   // result
   always_comb begin
      res                    = '0;
      res.current_state      = state_in;
      res.current_generation = gen_in;
      res.event_state        = state_in;
      res.event_generation   = tag;
      res.event_stage        = STAGE_CONNECT;
      res.event_failure      = FAIL_NONE;
      case (kind)
         REQ_CONNECT: begin
            if (state_ff != ST_DISCONNECTED) begin
               res.status = STATUS_INVALID_STATE;
            end else if (!start_ok) begin
               res.status = STATUS_CONNECT_FAILED;
            end
         end
         REQ_CANCEL: begin
            if (state_ff != ST_CONNECTING) begin
               res.status = STATUS_INVALID_STATE;
            end
         end
         REQ_TEARDOWN: begin
            if (state_ff == ST_CONNECTED && !start_ok) begin
               res.status = STATUS_DISCONNECT_FAILED;
            end
         end
         REQ_DISCONNECT: begin
            if (state_ff != ST_CONNECTED) begin
               res.status = STATUS_INVALID_STATE;
            end else if (!start_ok) begin
               res.status = STATUS_DISCONNECT_FAILED;
            end
         end
         REQ_CONNECT_DONE: begin
            res.event_valid = conn_done_hit;
            if (cancel_ff) begin
               res.event_failure = (!ok && tfail) ? FAIL_TRANSPORT : FAIL_CANCELLED;
            end else if (tdown_ff && !ok) begin
               res.event_failure = FAIL_CANCELLED;
            end else begin
               res.event_failure = ok ? FAIL_NONE : FAIL_TRANSPORT;
            end
         end
         REQ_DISCONNECT_DONE: begin
            res.event_valid   = disc_done_hit;
            res.event_failure = ok ? FAIL_NONE : FAIL_TRANSPORT;
         end
         REQ_LINK_EVENT: begin
            res.event_valid   = link_hit;
            res.event_failure = ok ? FAIL_NONE : FAIL_TRANSPORT;
         end
         default: begin
            res.event_valid      = tick_fire;
            res.event_failure    = FAIL_UNRESPONSIVE;
            res.event_generation = gen_ff;
            res.event_stage      = stage_ff;
         end
      endcase
      if (!res.event_valid) begin
         res.event_state      = ST_DISCONNECTED;
         res.event_generation = '0;
         res.event_failure    = FAIL_NONE;
         res.event_stage      = STAGE_CONNECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_to_ff   <= TimeoutReset;
         disc_to_ff   <= TimeoutReset;
         cancel_to_ff <= TimeoutReset;
      end else if (csr_we) begin
         case (csr_index)
            CFG_CONNECT_TIMEOUT:    conn_to_ff   <= csr_wdata;
            CFG_DISCONNECT_TIMEOUT: disc_to_ff   <= csr_wdata;
            CFG_CANCEL_TIMEOUT:     cancel_to_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_DISCONNECTED;
         gen_ff    <= '0;
         cancel_ff <= 1'b0;
         tdown_ff  <= 1'b0;
         pend_ff   <= 1'b0;
         armed_ff  <= 1'b0;
         left_ff   <= '0;
         stage_ff  <= STAGE_CONNECT;
      end else if (acc) begin
         state_ff  <= state_in;
         gen_ff    <= gen_in;
         cancel_ff <= cancel_in;
         tdown_ff  <= tdown_in;
         pend_ff   <= pend_in;
         armed_ff  <= armed_in;
         left_ff   <= left_in;
         stage_ff  <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take || !out_valid_ff) begin
         out_valid_ff  <= skid_valid_ff || acc;
         skid_valid_ff <= 1'b0;
      end else if (acc) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // advance the skid entry first, else load the new result
   always_ff @(posedge clock) begin
      if (out_take || !out_valid_ff) begin
         out_ff <= skid_valid_ff ? skid_ff : res;
      end
      if (acc && out_valid_ff && !out_take) begin
         skid_ff <= res;
      end
   end

   `CLC_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `CLC_ASSERT_SAME(a_idle_states_not_pending, clock, reset,
      (state_ff == ST_DISCONNECTED || state_ff == ST_CONNECTED), !pend_ff)
   `CLC_ASSERT_NEXT(a_connect_bumps_generation, clock, reset,
      acc && kind == REQ_CONNECT && state_ff == ST_DISCONNECTED, gen_ff == $past(gen_ff) + 1'b1)
   `CLC_ASSERT_NEXT(a_skid_drains, clock, reset,
      out_take && skid_valid_ff, out_valid_ff && !skid_valid_ff)

endmodule

`default_nettype wire

// ===== tb/sv/connection_lifecycle_controller_tb.sv =====
module connection_lifecycle_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import clc_pkg::*;

   class link_lifecycle_scoreboard;
      link_state_type link_state;
      logic [31:0]    generation;
      bit             cancel_requested;
      bit             teardown_asked;
      bit             completion_due;
      bit             watchdog_armed;
      logic [15:0]    watchdog_left;
      stage_type      pending_stage;
      logic [15:0]    timeout_ticks [3];
      result_type     predicted_outcomes [$];
      result_type     outcome;

      function new();
         link_state         = ST_DISCONNECTED;
         generation         = '0;
         cancel_requested   = 1'b0;
         teardown_asked     = 1'b0;
         completion_due     = 1'b0;
         watchdog_armed     = 1'b0;
         watchdog_left      = '0;
         pending_stage      = STAGE_CONNECT;
         timeout_ticks[CFG_CONNECT_TIMEOUT]    = TimeoutReset;
         timeout_ticks[CFG_DISCONNECT_TIMEOUT] = TimeoutReset;
         timeout_ticks[CFG_CANCEL_TIMEOUT]     = TimeoutReset;
      endfunction

      function void set_timeout(cfg_index_type idx, logic [15:0] ticks);
         timeout_ticks[idx] = ticks;
      endfunction

      function int unsigned waiting();
         return predicted_outcomes.size();
      endfunction

      function void arm_watchdog(stage_type stage, logic [15:0] ticks);
         pending_stage  = stage;
         watchdog_armed = 1'b1;
         watchdog_left  = ticks;
      endfunction

      function void disarm_watchdog();
         completion_due = 1'b0;
         watchdog_armed = 1'b0;
      endfunction

      function void raise_event(logic [31:0] gen, failure_type fail, stage_type stage);
         outcome.event_valid      = 1'b1;
         outcome.event_state      = link_state;
         outcome.event_generation = gen;
         outcome.event_failure    = fail;
         outcome.event_stage      = stage;
      endfunction

      function status_type begin_disconnect(bit start_ok);
         link_state     = ST_DISCONNECTING;
         completion_due = 1'b1;
         arm_watchdog(STAGE_DISCONNECT, timeout_ticks[CFG_DISCONNECT_TIMEOUT]);
         if (!start_ok) begin
            link_state = ST_CONNECTED;
            disarm_watchdog();
            return STATUS_DISCONNECT_FAILED;
         end
         return STATUS_SUCCESS;
      endfunction

      function status_type tear_down(bit start_ok, bit cancel_ok);
         if (link_state == ST_DISCONNECTED || link_state == ST_DISCONNECTING)
            return STATUS_SUCCESS;
         teardown_asked = 1'b1;
         if (link_state == ST_CONNECTING) begin
            if (cancel_ok) begin
               link_state       = ST_DISCONNECTING;
               cancel_requested = 1'b1;
               arm_watchdog(STAGE_CANCEL, timeout_ticks[CFG_CANCEL_TIMEOUT]);
            end
            return STATUS_SUCCESS;
         end
         cancel_requested = 1'b0;
         teardown_asked   = 1'b0;
         return begin_disconnect(start_ok);
      endfunction

      function void note_request(req_kind_type kind, logic [31:0] tag, bit ok, bit tfail,
                                 bit down, bit start_ok, bit cancel_ok);
         failure_type fail;
         outcome = '0;
         case (kind)
            REQ_CONNECT: begin
               if (link_state != ST_DISCONNECTED) begin
                  outcome.status = STATUS_INVALID_STATE;
               end else begin
                  generation       = generation + 32'd1;
                  link_state       = ST_CONNECTING;
                  cancel_requested = 1'b0;
                  teardown_asked   = 1'b0;
                  completion_due   = 1'b1;
                  arm_watchdog(STAGE_CONNECT, timeout_ticks[CFG_CONNECT_TIMEOUT]);
                  if (!start_ok) begin
                     link_state = ST_DISCONNECTED;
                     disarm_watchdog();
                     outcome.status = STATUS_CONNECT_FAILED;
                  end
               end
            end
            REQ_CANCEL: begin
               if (link_state != ST_CONNECTING)
                  outcome.status = STATUS_INVALID_STATE;
               else
                  outcome.status = tear_down(start_ok, cancel_ok);
            end
            REQ_TEARDOWN: outcome.status = tear_down(start_ok, cancel_ok);
            REQ_DISCONNECT: begin
               if (link_state != ST_CONNECTED)
                  outcome.status = STATUS_INVALID_STATE;
               else
                  outcome.status = begin_disconnect(start_ok);
            end
            REQ_CONNECT_DONE: begin
               if (tag == generation && completion_due &&
                   (link_state == ST_CONNECTING || link_state == ST_DISCONNECTING)) begin
                  disarm_watchdog();
                  if (cancel_requested) begin
                     if (!ok && tfail) begin
                        fail       = FAIL_TRANSPORT;
                        link_state = ST_CONNECTED;
                     end else begin
                        fail       = FAIL_CANCELLED;
                        link_state = ST_DISCONNECTED;
                     end
                  end else if (teardown_asked && !ok) begin
                     fail       = FAIL_CANCELLED;
                     link_state = ST_DISCONNECTED;
                  end else if (ok) begin
                     fail       = FAIL_NONE;
                     link_state = ST_CONNECTED;
                  end else begin
                     fail       = FAIL_TRANSPORT;
                     link_state = ST_DISCONNECTED;
                  end
                  cancel_requested = 1'b0;
                  teardown_asked   = 1'b0;
                  raise_event(tag, fail, STAGE_CONNECT);
               end
            end
            REQ_DISCONNECT_DONE: begin
               if (tag == generation && completion_due &&
                   link_state == ST_DISCONNECTING) begin
                  disarm_watchdog();
                  if (ok) begin
                     link_state = ST_DISCONNECTED;
                     raise_event(tag, FAIL_NONE, STAGE_CONNECT);
                  end else begin
                     link_state = ST_CONNECTED;
                     raise_event(tag, FAIL_TRANSPORT, STAGE_CONNECT);
                  end
               end
            end
            REQ_LINK_EVENT: begin
               if (tag == generation && link_state == ST_CONNECTED && down) begin
                  link_state = ST_DISCONNECTED;
                  raise_event(tag, ok ? FAIL_NONE : FAIL_TRANSPORT, STAGE_CONNECT);
               end
            end
            default: begin
               if (completion_due && watchdog_armed) begin
                  if (watchdog_left <= 16'd1) begin
                     disarm_watchdog();
                     watchdog_left = '0;
                     raise_event(generation, FAIL_UNRESPONSIVE, pending_stage);
                  end else begin
                     watchdog_left = watchdog_left - 16'd1;
                  end
               end
            end
         endcase
         outcome.current_state      = link_state;
         outcome.current_generation = generation;
         predicted_outcomes.push_back(outcome);
      endfunction

      function bit check_result(result_type got, output string diff);
         result_type want;
         want = predicted_outcomes.pop_front();
         diff = "";
         if (got.status !== want.status)
            diff = {diff, $sformatf(" status %0d/%0d", got.status, want.status)};
         if (got.event_valid !== want.event_valid)
            diff = {diff, $sformatf(" event_valid %0d/%0d", got.event_valid, want.event_valid)};
         if (got.event_state !== want.event_state)
            diff = {diff, $sformatf(" event_state %0d/%0d", got.event_state, want.event_state)};
         if (got.event_generation !== want.event_generation)
            diff = {diff, $sformatf(" event_generation %h/%h",
                                    got.event_generation, want.event_generation)};
         if (got.event_failure !== want.event_failure)
            diff = {diff, $sformatf(" event_failure %0d/%0d",
                                    got.event_failure, want.event_failure)};
         if (got.event_stage !== want.event_stage)
            diff = {diff, $sformatf(" event_stage %0d/%0d", got.event_stage, want.event_stage)};
         if (got.current_state !== want.current_state)
            diff = {diff, $sformatf(" current_state %0d/%0d",
                                    got.current_state, want.current_state)};
         if (got.current_generation !== want.current_generation)
            diff = {diff, $sformatf(" current_generation %h/%h",
                                    got.current_generation, want.current_generation)};
         if (diff != "")
            diff = {"result fields (got/expected):", diff};
         return diff == "";
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // tag[31:0], ok, tfail, link_down,
                                  // start_ok, cancel_accepted, zero pad
   logic [2:0]  req_tuser = '0;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // status, event_valid, event_state, event_generation,
                                  // event_failure, event_stage, current_state,
                                  // current_generation, zero pad
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   link_lifecycle_scoreboard sb;
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned next_hold_at = 300;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;
   int unsigned quiet_left = 0;
   int unsigned steady_items = 0;
   result_type  observed;
   string       diff;

   connection_lifecycle_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100)
         $display("%0t ns: %s", $time, what);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic int unsigned sender_gap();
      if (steady_items != 0) begin
         steady_items--;
         return 0;
      end
      if ($urandom_range(0, 99) == 0)
         steady_items = $urandom_range(40, 150);
      return pick_gap();
   endfunction

   // Call at a falling edge; returns at the falling edge after the transaction.
   task automatic send_request(req_kind_type kind, logic [31:0] tag, bit ok, bit tfail,
                               bit down, bit start_ok, bit cancel_ok);
      int unsigned gap;
      gap = sender_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, cancel_ok, start_ok, down, tfail, ok, tag};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, tag, ok, tfail, down, start_ok, cancel_ok);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.waiting() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_timeout(cfg_index_type idx, logic [15:0] ticks);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= ticks;
      sb.set_timeout(idx, ticks);
      @(negedge clock);
   endtask

   task automatic load_timeouts(logic [15:0] conn, logic [15:0] disc, logic [15:0] canc);
      write_timeout(CFG_CONNECT_TIMEOUT, conn);
      write_timeout(CFG_DISCONNECT_TIMEOUT, disc);
      write_timeout(CFG_CANCEL_TIMEOUT, canc);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_request(bit allow_expiry);
      req_kind_type kind;
      logic [31:0]  tag;
      int unsigned  r;
      r    = $urandom_range(0, 99);
      kind = req_kind_type'($urandom_range(0, 7));
      case (sb.link_state)
         ST_DISCONNECTED: begin
            if (r < 55) kind = REQ_CONNECT;
         end
         ST_CONNECTING: begin
            if (r < 35)      kind = REQ_CONNECT_DONE;
            else if (r < 50) kind = REQ_CANCEL;
            else if (r < 60) kind = REQ_TEARDOWN;
            else if (r < 80) kind = REQ_TICK;
         end
         ST_CONNECTED: begin
            if (r < 30)      kind = REQ_DISCONNECT;
            else if (r < 40) kind = REQ_TEARDOWN;
            else if (r < 55) kind = REQ_LINK_EVENT;
            else if (r < 75) kind = REQ_TICK;
         end
         default: begin
            if (r < 30)      kind = REQ_DISCONNECT_DONE;
            else if (r < 45) kind = REQ_CONNECT_DONE;
            else if (r < 70) kind = REQ_TICK;
         end
      endcase
      // an expiry leaves the link stuck until reset, so keep it for the end
      if (!allow_expiry && kind == REQ_TICK && sb.completion_due &&
          sb.watchdog_armed && sb.watchdog_left <= 16'd1)
         kind = REQ_CONNECT;
      tag = ($urandom_range(0, 99) < 88) ? sb.generation : $urandom;
      send_request(kind, tag, $urandom_range(0, 3) != 0, $urandom_range(0, 1) != 0,
                   $urandom_range(0, 4) != 0, $urandom_range(0, 7) != 0,
                   $urandom_range(0, 9) < 7);
   endtask

   task automatic run_directed();
      send_request(REQ_TICK, 32'h0, 1, 0, 0, 1, 1);
      send_request(REQ_CONNECT_DONE, 32'h0, 1, 0, 0, 1, 1);
      send_request(REQ_DISCONNECT, 32'h0, 1, 0, 0, 1, 1);
      send_request(REQ_CANCEL, 32'h0, 1, 0, 0, 1, 1);
      send_request(REQ_TEARDOWN, 32'h0, 1, 0, 0, 1, 1);
      send_request(REQ_LINK_EVENT, 32'h0, 0, 0, 1, 1, 1);
      send_request(REQ_CONNECT, 32'h0, 1, 0, 0, 0, 1);
      send_request(REQ_CONNECT, 32'h0, 1, 0, 0, 1, 1);
      send_request(REQ_CONNECT, 32'h0, 1, 0, 0, 1, 1);
      send_request(REQ_TICK, 32'h0, 1, 0, 0, 1, 1);
      send_request(REQ_CONNECT_DONE, 32'hFFFF_FFFF, 1, 1, 1, 1, 1);
      send_request(REQ_TEARDOWN, 32'h0, 1, 0, 0, 1, 0);
      send_request(REQ_CONNECT_DONE, sb.generation, 0, 0, 0, 1, 1);
      send_request(REQ_CONNECT, 32'h0, 1, 0, 0, 1, 1);
      send_request(REQ_CANCEL, 32'h0, 1, 0, 0, 1, 1);
      send_request(REQ_CONNECT_DONE, sb.generation, 0, 1, 0, 1, 1);
      send_request(REQ_DISCONNECT, 32'h0, 1, 0, 0, 0, 1);
      send_request(REQ_LINK_EVENT, sb.generation, 1, 0, 0, 1, 1);
      send_request(REQ_LINK_EVENT, sb.generation, 0, 0, 1, 1, 1);
      send_request(REQ_CONNECT, 32'h0, 1, 0, 0, 1, 1);
      send_request(REQ_CONNECT_DONE, sb.generation, 1, 0, 0, 1, 1);
      send_request(REQ_TEARDOWN, 32'h0, 1, 0, 0, 1, 1);
      send_request(REQ_DISCONNECT_DONE, sb.generation, 0, 0, 0, 1, 1);
      send_request(REQ_DISCONNECT, 32'h0, 1, 0, 0, 1, 1);
      send_request(REQ_DISCONNECT_DONE, sb.generation, 1, 0, 0, 1, 1);
   endtask

   task automatic run_watchdog_expiry();
      stage_type target;
      target = stage_type'($urandom_range(0, 2));
      load_timeouts(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                    16'($urandom_range(1, 6)));
      while (sb.link_state != ST_DISCONNECTED) begin
         if (sb.link_state == ST_CONNECTED)
            send_request(REQ_LINK_EVENT, sb.generation, 1, 0, 1, 1, 1);
         else
            send_request(REQ_CONNECT_DONE, sb.generation, 0, 0, 0, 1, 1);
      end
      send_request(REQ_CONNECT, 32'h0, 1, 0, 0, 1, 1);
      if (target == STAGE_CANCEL) begin
         send_request(REQ_CANCEL, 32'h0, 1, 0, 0, 1, 1);
      end else if (target == STAGE_DISCONNECT) begin
         send_request(REQ_CONNECT_DONE, sb.generation, 1, 0, 0, 1, 1);
         send_request(REQ_DISCONNECT, 32'h0, 1, 0, 0, 1, 1);
      end
      while (sb.completion_due)
         send_request(REQ_TICK, sb.generation, 1, 0, 0, 1, 1);
   endtask

   initial begin
      sb = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      run_directed();
      for (int phase = 0; phase < 6; phase++) begin
         drain_results();
         case (phase)
            0: load_timeouts(16'hFFFF, 16'hFFFF, 16'hFFFF);
            1: load_timeouts(16'd1, 16'd1, 16'd1);
            2: load_timeouts(16'($urandom_range(2, 12)), 16'($urandom_range(2, 12)),
                             16'($urandom_range(2, 12)));
            3: load_timeouts(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                             16'($urandom_range(1, 65535)));
            4: load_timeouts(16'($urandom_range(2, 40)), 16'($urandom_range(2, 40)),
                             16'($urandom_range(2, 40)));
            default: load_timeouts(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                                   16'($urandom_range(1, 8)));
         endcase
         repeat (280) send_random_request(1'b0);
      end
      drain_results();
      run_watchdog_expiry();
      repeat (10) send_random_request(1'b1);
      drain_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Hold off for long stretches now and then so that the block fills and stalls.
   initial begin
      forever begin
         @(negedge clock);
         if (!reset && hold_left == 0 && results_seen >= next_hold_at) begin
            hold_left    = 80;
            next_hold_at = next_hold_at + 700;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (quiet_left != 0) begin
               quiet_left--;
            end else begin
               if ($urandom_range(0, 3) == 0)
                  stall_left = pick_gap();
               if ($urandom_range(0, 149) == 0)
                  quiet_left = $urandom_range(30, 120);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed = result_type'(rsp_tdata[ResultWidth-1:0]);
         results_seen++;
         if (sb.waiting() == 0)
            report_mismatch("result transaction with no prediction waiting");
         else if (!sb.check_result(observed, diff))
            report_mismatch(diff);
      end
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
